// File: rtl/assert_macros.svh
// Assertion macros for the interleaver RTL, used by pis_ctrl.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PIS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define PIS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pis_pkg.sv
// Package for the permutation interleaver: widths, codes, state and control types.
// No dependencies; imported by pis_spread, pis_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none
package pis_pkg;

   localparam int ADDR_W   = 10;
   localparam int DEPTH    = 1024;
   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 11;
   localparam int WIN_W    = 6;
   localparam int COUNT_W  = 16;
   localparam int IDX_W    = 2;

   localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(DEPTH);
   localparam logic [LEN_W-1:0] RESET_LEN     = LEN_W'(1024);
   localparam logic [WIN_W-1:0] RESET_WINDOW  = WIN_W'(45);

   typedef enum logic [IDX_W-1:0] {
      CSR_BLOCK_LEN = 2'd0,
      CSR_WINDOW    = 2'd1,
      CSR_DIRECTION = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      MODE_TABLE  = 2'd0,
      MODE_SAMPLE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_SPREAD = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ACK    = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_SPREAD = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWR,
      ST_TRD,
      ST_SRD,
      ST_WI,
      ST_WA,
      ST_WB
   } state_type;

   typedef struct packed {
      logic             init;
      logic             update;
      logic [LEN_W-1:0] init_len;
   } spr_ctl_type;

endpackage
`default_nettype wire

// File: rtl/pis_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pis_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/pis_spread.sv
// Spread accumulator: pair distance, running minimum and saturating count of close pairs.
// Depends on pis_pkg; driven by pis_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module pis_spread
   import pis_pkg::*;
(
   input  wire logic                 clock,
   input  wire spr_ctl_type          ctl,
   input  wire logic [ADDR_W-1:0]    val_a,
   input  wire logic [ADDR_W-1:0]    val_b,
   input  wire logic [WIN_W-1:0]     gap,
   input  wire logic [WIN_W-1:0]     window,
   output logic      [LEN_W-1:0]     min_spread,
   output logic      [COUNT_W-1:0]   bad_count
);

   logic [LEN_W-1:0]   spread_ff, spread_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  diff;
   logic [LEN_W-1:0]   pair_d;
   logic [WIN_W-1:0]   half;

   always_comb begin
      diff   = (val_a > val_b) ? (val_a - val_b) : (val_b - val_a);
      pair_d = LEN_W'(diff) + LEN_W'(gap);
      half   = window >> 1;
      spread_in = spread_ff;
      count_in  = count_ff;
      if (ctl.init) begin
         spread_in = ctl.init_len;
         count_in  = '0;
      end else if (ctl.update) begin
         if (pair_d < spread_ff) begin
            spread_in = pair_d;
         end
         if ((pair_d < LEN_W'(half)) && (count_ff != '1)) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      spread_ff <= spread_in;
      count_ff  <= count_in;
   end

   assign min_spread = spread_ff;
   assign bad_count  = count_ff;

endmodule
`default_nettype wire

// File: rtl/pis_ctrl.sv
// Sequencer of the interleaver: memory accesses per transaction, spread walk, result register.
// Depends on pis_pkg and assert_macros.svh; drives both RAMs and pis_spread.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pis_ctrl
   import pis_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_mode,
   input  wire logic [ADDR_W-1:0]    req_position,
   input  wire logic [ADDR_W-1:0]    req_table_value,
   input  wire logic [SAMPLE_W-1:0]  req_sample_in,
   input  wire logic [LEN_W-1:0]     block_len,
   input  wire logic [WIN_W-1:0]     window,
   input  wire logic                 direction,
   output logic                      tab_we,
   output logic      [ADDR_W-1:0]    tab_waddr,
   output logic      [ADDR_W-1:0]    tab_wdata,
   output logic      [ADDR_W-1:0]    tab_raddr,
   input  wire logic [ADDR_W-1:0]    tab_rdata,
   output logic                      smp_we,
   output logic      [ADDR_W-1:0]    smp_waddr,
   output logic      [SAMPLE_W-1:0]  smp_wdata,
   output logic      [ADDR_W-1:0]    smp_raddr,
   input  wire logic [SAMPLE_W-1:0]  smp_rdata,
   output spr_ctl_type               spr_ctl,
   output logic      [ADDR_W-1:0]    spr_a,
   output logic      [ADDR_W-1:0]    spr_b,
   output logic      [WIN_W-1:0]     spr_gap,
   input  wire logic [LEN_W-1:0]     min_spread,
   input  wire logic [COUNT_W-1:0]   bad_count,
   output logic                      rsp_valid,
   output logic      [1:0]           rsp_kind,
   output logic      [SAMPLE_W-1:0]  rsp_sample_out,
   output logic      [LEN_W-1:0]     rsp_min_spread,
   output logic      [COUNT_W-1:0]   rsp_bad_pair_count
);

   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    i_ff, i_in;
   logic [LEN_W-1:0]    j_ff, j_in;
   logic [ADDR_W-1:0]   a_ff, a_in;
   logic [SAMPLE_W-1:0] hold_ff, hold_in;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [LEN_W-1:0]    rsp_min_ff, rsp_min_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                accept;
   mode_type            mode_sel;
   logic [LEN_W-1:0]    n_eff;
   logic [LEN_W-1:0]    i_inc;
   logic [LEN_W-1:0]    j_inc;
   logic [WIN_W-1:0]    gap;
   logic                walk_end;
   logic                more_j;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign mode_sel = mode_type'(req_mode);
   assign n_eff    = (block_len > MAX_LEN) ? MAX_LEN : block_len;
   assign i_inc    = i_ff + LEN_W'(1);
   assign j_inc    = j_ff + LEN_W'(1);
   assign gap      = WIN_W'(j_ff - i_ff);
   assign walk_end = (i_inc >= n_eff) || (window == '0);
   assign more_j   = (j_inc < n_eff) && (gap < window);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode_sel)
                  MODE_TABLE:  state_in = ST_IDLE;
                  MODE_SAMPLE: state_in = direction ? ST_SWR : ST_IDLE;
                  MODE_READ:   state_in = direction ? ST_SRD : ST_TRD;
                  MODE_SPREAD: state_in = ST_WI;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SWR:  state_in = ST_IDLE;
         ST_TRD:  state_in = ST_SRD;
         ST_SRD:  state_in = ST_IDLE;
         ST_WI:   state_in = walk_end ? ST_IDLE : ST_WA;
         ST_WA:   state_in = ST_WB;
         ST_WB:   state_in = more_j ? ST_WB : ST_WI;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      tab_we        = 1'b0;
      tab_waddr     = req_position;
      tab_wdata     = req_table_value;
      tab_raddr     = req_position;
      smp_we        = 1'b0;
      smp_waddr     = req_position;
      smp_wdata     = req_sample_in;
      smp_raddr     = req_position;
      spr_ctl       = '0;
      spr_ctl.init_len = n_eff;
      i_in          = i_ff;
      j_in          = j_ff;
      a_in          = a_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_ACK;
      rsp_sample_in = '0;
      rsp_min_in    = '0;
      rsp_count_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode_sel)
                  MODE_TABLE: begin
                     tab_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_SAMPLE: begin
                     hold_in = req_sample_in;
                     if (!direction) begin
                        smp_we       = 1'b1;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  MODE_SPREAD: begin
                     i_in         = '0;
                     spr_ctl.init = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_SWR: begin
            smp_we       = 1'b1;
            smp_waddr    = tab_rdata;
            smp_wdata    = hold_ff;
            rsp_valid_in = 1'b1;
         end
         ST_TRD: begin
            smp_raddr = tab_rdata;
         end
         ST_SRD: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_SAMPLE;
            rsp_sample_in = smp_rdata;
         end
         ST_WI: begin
            tab_raddr = i_ff[ADDR_W-1:0];
            if (walk_end) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SPREAD;
               rsp_min_in   = min_spread;
               rsp_count_in = bad_count;
            end
         end
         ST_WA: begin
            a_in      = tab_rdata;
            j_in      = i_inc;
            tab_raddr = i_inc[ADDR_W-1:0];
         end
         ST_WB: begin
            spr_ctl.update = 1'b1;
            if (more_j) begin
               j_in      = j_inc;
               tab_raddr = j_inc[ADDR_W-1:0];
            end else begin
               i_in = i_inc;
            end
         end
         default: ;
      endcase
   end

   assign spr_a   = a_ff;
   assign spr_b   = tab_rdata;
   assign spr_gap = gap;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      a_ff          <= a_in;
      hold_ff       <= hold_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_sample_out     = rsp_sample_ff;
   assign rsp_min_spread     = rsp_min_ff;
   assign rsp_bad_pair_count = rsp_count_ff;

   `PIS_ASSERT_IMP(a_walk_order, clock, reset, state_ff == ST_WB, (j_ff > i_ff) && (j_ff < n_eff) && (gap <= window), "spread walk left its pair window")
   `PIS_ASSERT_IMP(a_smp_write_state, clock, reset, smp_we, (state_ff == ST_IDLE) || (state_ff == ST_SWR), "sample write outside a write transaction")
   `PIS_ASSERT_NEXT(a_table_ack, clock, reset, accept && (req_mode == MODE_TABLE), rsp_valid_ff && (rsp_kind_ff == KIND_ACK) && (state_ff == ST_IDLE), "table write not acknowledged")
   `PIS_ASSERT_NEXT(a_read_result, clock, reset, state_ff == ST_SRD, rsp_valid_ff && (rsp_kind_ff == KIND_SAMPLE), "sample read gave no result")

endmodule
`default_nettype wire

// File: rtl/permutation_interleaver_with_spread_unit.sv
// Top level of the permutation interleaver: configuration registers, table and sample RAMs.
// Depends on pis_pkg, pis_ram, pis_spread and pis_ctrl.
//
// One transaction is accepted when start is high and busy is low; each gives one result,
// shown for one cycle with rsp_valid and never held, so the receiver must take it then.
// Table writes and interleave-direction sample writes are done in the accepting cycle, and a
// new transaction may follow at once. A deinterleave sample write reads the table and then
// writes the sample RAM, a deinterleave read reads only the sample RAM, and an interleave
// read reads the table and then the sample RAM in turn. A spread check walks the table through
// its single read port: for each position i it reads entry i, then compares it with every
// later entry j up to min(i+W, N-1); it closes when i+1 reaches N or the window W is zero.
// Both stores are undefined until written; there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module permutation_interleaver_with_spread_unit
   import pis_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_mode,
   input  wire logic [ADDR_W-1:0]    req_position,
   input  wire logic [ADDR_W-1:0]    req_table_value,
   input  wire logic [SAMPLE_W-1:0]  req_sample_in,
   output logic                      rsp_valid,
   output logic      [1:0]           rsp_kind,
   output logic      [SAMPLE_W-1:0]  rsp_sample_out,
   output logic      [LEN_W-1:0]     rsp_min_spread,
   output logic      [COUNT_W-1:0]   rsp_bad_pair_count,
   input  wire logic                 csr_wr_en,
   input  wire logic [IDX_W-1:0]     csr_index,
   input  wire logic [LEN_W-1:0]     csr_wdata
);

   logic [LEN_W-1:0] block_len_ff, block_len_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic             direction_ff, direction_in;

   logic                tab_we;
   logic [ADDR_W-1:0]   tab_waddr, tab_wdata, tab_raddr, tab_rdata;
   logic                smp_we;
   logic [ADDR_W-1:0]   smp_waddr, smp_raddr;
   logic [SAMPLE_W-1:0] smp_wdata, smp_rdata;
   spr_ctl_type         spr_ctl;
   logic [ADDR_W-1:0]   spr_a, spr_b;
   logic [WIN_W-1:0]    spr_gap;
   logic [LEN_W-1:0]    min_spread;
   logic [COUNT_W-1:0]  bad_count;

   always_comb begin
      block_len_in = block_len_ff;
      window_in    = window_ff;
      direction_in = direction_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BLOCK_LEN: block_len_in = csr_wdata;
            CSR_WINDOW:    window_in    = csr_wdata[WIN_W-1:0];
            CSR_DIRECTION: direction_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff <= RESET_LEN;
         window_ff    <= RESET_WINDOW;
         direction_ff <= 1'b0;
      end else begin
         block_len_ff <= block_len_in;
         window_ff    <= window_in;
         direction_ff <= direction_in;
      end
   end

   pis_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (DEPTH)
   ) u_table_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (tab_waddr),
      .wdata (tab_wdata),
      .raddr (tab_raddr),
      .rdata (tab_rdata)
   );

   pis_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_sample_ram (
      .clock (clock),
      .we    (smp_we),
      .waddr (smp_waddr),
      .wdata (smp_wdata),
      .raddr (smp_raddr),
      .rdata (smp_rdata)
   );

   pis_spread u_spread (
      .clock      (clock),
      .ctl        (spr_ctl),
      .val_a      (spr_a),
      .val_b      (spr_b),
      .gap        (spr_gap),
      .window     (window_ff),
      .min_spread (min_spread),
      .bad_count  (bad_count)
   );

   pis_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_table_value    (req_table_value),
      .req_sample_in      (req_sample_in),
      .block_len          (block_len_ff),
      .window             (window_ff),
      .direction          (direction_ff),
      .tab_we             (tab_we),
      .tab_waddr          (tab_waddr),
      .tab_wdata          (tab_wdata),
      .tab_raddr          (tab_raddr),
      .tab_rdata          (tab_rdata),
      .smp_we             (smp_we),
      .smp_waddr          (smp_waddr),
      .smp_wdata          (smp_wdata),
      .smp_raddr          (smp_raddr),
      .smp_rdata          (smp_rdata),
      .spr_ctl            (spr_ctl),
      .spr_a              (spr_a),
      .spr_b              (spr_b),
      .spr_gap            (spr_gap),
      .min_spread         (min_spread),
      .bad_count          (bad_count),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_min_spread     (rsp_min_spread),
      .rsp_bad_pair_count (rsp_bad_pair_count)
   );

endmodule
`default_nettype wire
